>>> src/vgsg_pkg.sv
// Shared types and constants for the voxel grid splat and gather block.
package vgsg_pkg;

    localparam int POS_W = 14;
    localparam int VEL_W = 16;
    localparam int W_W   = 17;               // Q0.16 weight, 1.0 included
    localparam int LO_W  = 8;                // lower corner index, largest grid
    localparam int DEN_W = 32;
    localparam int SUM_W = 48;
    localparam int ACC_W = 40;
    localparam int CELL_W = DEN_W + 3 * SUM_W;
    localparam int AVG_W = 16;
    localparam int GRAD_W = 32;
    localparam int T_W = 33;                 // gradient term width

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_SPLAT  = 2'd1,
        ACT_GATHER = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_SPLAT,
        CMD_GATHER,
        CMD_SKIP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic                     status;
        logic [LO_W-1:0]          lo_x;
        logic [LO_W-1:0]          lo_y;
        logic [LO_W-1:0]          lo_z;
        logic [W_W-1:0]           wl_x;
        logic [W_W-1:0]           wh_x;
        logic [W_W-1:0]           wl_y;
        logic [W_W-1:0]           wh_y;
        logic [W_W-1:0]           wl_z;
        logic [W_W-1:0]           wh_z;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic signed [VEL_W-1:0]  vel_z;
    } cmd_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_RD,
        B_WGT,
        B_SPL,
        B_WR,
        B_GT,
        B_GACC,
        B_DIV,
        B_QMUL,
        B_QACC,
        B_DONE
    } back_state_t;

endpackage

>>> src/vgsg_front.sv
// Front end: decodes an item into corner indices, weights and a command kind.
module vgsg_front #(
    parameter int GRID_SIZE = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  vgsg_pkg::action_t                     action,
    input  logic signed [vgsg_pkg::POS_W-1:0]     pos_x,
    input  logic signed [vgsg_pkg::POS_W-1:0]     pos_y,
    input  logic signed [vgsg_pkg::POS_W-1:0]     pos_z,
    input  logic signed [vgsg_pkg::VEL_W-1:0]     vel_x,
    input  logic signed [vgsg_pkg::VEL_W-1:0]     vel_y,
    input  logic signed [vgsg_pkg::VEL_W-1:0]     vel_z,
    input  logic                                  q_full,
    input  logic                                  init_busy,
    output logic                                  push,
    output vgsg_pkg::cmd_t                        cmd
);
    import vgsg_pkg::*;

    localparam int HALF = GRID_SIZE / 2;
    localparam int WSH  = 16 - FRAC_BITS;
    localparam logic [W_W-1:0] FONE = W_W'(1 << FRAC_BITS);

    function automatic logic signed [15:0] lo_of(input logic signed [POS_W-1:0] p);
        logic signed [POS_W-1:0] b;
        b = p >>> FRAC_BITS;
        lo_of = 16'(b) + 16'(HALF);
    endfunction

    function automatic logic outside(input logic signed [15:0] lo);
        outside = (lo < 16'sd0) || (lo >= 16'(GRID_SIZE - 1));
    endfunction

    function automatic logic [W_W-1:0] w_lo(input logic signed [POS_W-1:0] p);
        w_lo = (FONE - W_W'(p[FRAC_BITS-1:0])) << WSH;
    endfunction

    function automatic logic [W_W-1:0] w_hi(input logic signed [POS_W-1:0] p);
        w_hi = W_W'(p[FRAC_BITS-1:0]) << WSH;
    endfunction

    logic signed [15:0] lo_x, lo_y, lo_z;
    logic               off_grid;

    assign s_tready = !q_full && !init_busy;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        lo_x = lo_of(pos_x);
        lo_y = lo_of(pos_y);
        lo_z = lo_of(pos_z);
        off_grid = outside(lo_x) || outside(lo_y) || outside(lo_z);

        cmd.kind   = CMD_SKIP;
        cmd.status = 1'b0;
        cmd.lo_x   = LO_W'(lo_x);
        cmd.lo_y   = LO_W'(lo_y);
        cmd.lo_z   = LO_W'(lo_z);
        cmd.wl_x   = w_lo(pos_x);
        cmd.wh_x   = w_hi(pos_x);
        cmd.wl_y   = w_lo(pos_y);
        cmd.wh_y   = w_hi(pos_y);
        cmd.wl_z   = w_lo(pos_z);
        cmd.wh_z   = w_hi(pos_z);
        cmd.vel_x  = vel_x;
        cmd.vel_y  = vel_y;
        cmd.vel_z  = vel_z;

        case (action)
            ACT_CLEAR: begin
                cmd.kind = CMD_CLEAR;
            end
            ACT_SPLAT: begin
                cmd.kind   = off_grid ? CMD_SKIP : CMD_SPLAT;
                cmd.status = off_grid;
            end
            ACT_GATHER: begin
                cmd.kind   = off_grid ? CMD_SKIP : CMD_GATHER;
                cmd.status = off_grid;
            end
            default: begin
                cmd.kind = CMD_SKIP;
            end
        endcase
    end

endmodule

>>> src/vgsg_fifo.sv
// Two-entry command queue between front and back.
module vgsg_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  vgsg_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output vgsg_pkg::cmd_t  head,
    output logic [1:0]      count
);
    import vgsg_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/vgsg_div.sv
// Restoring divider, one quotient bit a cycle: 48-bit magnitude by 32-bit divisor.
module vgsg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [vgsg_pkg::SUM_W-1:0]    dividend,
    input  logic [vgsg_pkg::DEN_W-1:0]    divisor,
    output logic                          done,
    output logic [vgsg_pkg::SUM_W-1:0]    quotient
);
    import vgsg_pkg::*;

    logic             busy_reg, busy_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] dvs_reg, dvs_next;
    logic [DEN_W:0]   trial;

    assign done     = busy_reg && (cnt_reg == 6'd0);
    assign quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'(SUM_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 6'd1;
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_next = DEN_W'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[DEN_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

>>> src/vgsg_back.sv
// Back end: grid memory, corner sequencer, splat and gather arithmetic, result register.
module vgsg_back #(
    parameter int GRID_SIZE = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cmd_valid,
    input  vgsg_pkg::cmd_t                       cmd,
    output logic                                 cmd_pop,
    output logic                                 init_busy,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic signed [vgsg_pkg::AVG_W-1:0]    avg_vel_x,
    output logic signed [vgsg_pkg::AVG_W-1:0]    avg_vel_y,
    output logic signed [vgsg_pkg::AVG_W-1:0]    avg_vel_z,
    output logic signed [vgsg_pkg::GRAD_W-1:0]   grad_x,
    output logic signed [vgsg_pkg::GRAD_W-1:0]   grad_y,
    output logic signed [vgsg_pkg::GRAD_W-1:0]   grad_z,
    output logic                                 status
);
    import vgsg_pkg::*;

    localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_A   = ADDR_W'(GRID_SIZE);
    localparam logic [ADDR_W-1:0] PLANE_A = ADDR_W'(GRID_SIZE * GRID_SIZE);

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
        if (s[SUM_W] != s[SUM_W-1]) begin
            sat_sum = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat_sum = s[SUM_W-1:0];
        end
    endfunction

    function automatic logic signed [AVG_W-1:0] sat_avg(input logic signed [ACC_W-1:0] a);
        if (a > ACC_W'(32767)) begin
            sat_avg = 16'sh7FFF;
        end else if (a < -ACC_W'(32768)) begin
            sat_avg = 16'sh8000;
        end else begin
            sat_avg = a[AVG_W-1:0];
        end
    endfunction

    function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [ACC_W-1:0] a);
        if (a > ACC_W'(64'sh7FFF_FFFF)) begin
            sat_grad = 32'sh7FFF_FFFF;
        end else if (a < -ACC_W'(64'sh8000_0000)) begin
            sat_grad = 32'sh8000_0000;
        end else begin
            sat_grad = a[GRAD_W-1:0];
        end
    endfunction

    // grid memory, cell layout {vel_z, vel_y, vel_x, density}
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [CELL_W-1:0] mem_wdata;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [2:0]        corner_reg, corner_next;
    logic [1:0]        axis_reg, axis_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              init_reg, init_next;
    logic              m_valid_reg, m_valid_next;

    logic [W_W-1:0]    pxy_reg, pxy_next, pxz_reg, pxz_next, pyz_reg, pyz_next;
    logic [W_W-1:0]    w_reg, w_next;
    logic signed [33:0] vwx_reg, vwx_next, vwy_reg, vwy_next, vwz_reg, vwz_next;
    logic [T_W-1:0]    tx_reg, tx_next, ty_reg, ty_next, tz_reg, tz_next;
    logic signed [ACC_W-1:0] gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic signed [ACC_W-1:0] ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic signed [31:0] q_reg, q_next;
    logic signed [33:0] qw_reg, qw_next;

    logic signed [AVG_W-1:0]  oax_reg, oax_next, oay_reg, oay_next, oaz_reg, oaz_next;
    logic signed [GRAD_W-1:0] ogx_reg, ogx_next, ogy_reg, ogy_next, ogz_reg, ogz_next;
    logic                     ost_reg, ost_next;

    // corner decode and cell fields
    logic              dx, dy, dz, last_corner, out_free, div_done, div_start;
    logic [W_W-1:0]    wx, wy, wz;
    logic [ADDR_W-1:0] cell_addr;
    logic [DEN_W-1:0]  rd_den;
    logic signed [SUM_W-1:0] rd_vx, rd_vy, rd_vz, vs_div, vs_cur;
    logic [1:0]        div_axis;
    logic [SUM_W-1:0]  div_mag, div_quo;
    logic [2*W_W-1:0]  p_xy, p_xz, p_yz, p_w;
    logic [48:0]       p_tx, p_ty, p_tz;
    logic signed [33:0] w_s;
    logic signed [49:0] p_qw;
    logic [DEN_W:0]    den_sum;
    logic [DEN_W-1:0]  den_new;
    logic signed [ACC_W-1:0] qw_ext;

    assign dx = corner_reg[2];
    assign dy = corner_reg[1];
    assign dz = corner_reg[0];
    assign last_corner = (corner_reg == 3'd7);
    assign out_free    = !m_valid_reg || m_tready;
    assign wx = dx ? cmd_reg.wh_x : cmd_reg.wl_x;
    assign wy = dy ? cmd_reg.wh_y : cmd_reg.wl_y;
    assign wz = dz ? cmd_reg.wh_z : cmd_reg.wl_z;

    assign cell_addr = (ADDR_W'(cmd_reg.lo_z) + ADDR_W'(dz)) * PLANE_A
                     + (ADDR_W'(cmd_reg.lo_y) + ADDR_W'(dy)) * ROW_A
                     + (ADDR_W'(cmd_reg.lo_x) + ADDR_W'(dx));

    assign rd_den = rd_reg[DEN_W-1:0];
    assign rd_vx  = rd_reg[DEN_W +: SUM_W];
    assign rd_vy  = rd_reg[DEN_W+SUM_W +: SUM_W];
    assign rd_vz  = rd_reg[DEN_W+2*SUM_W +: SUM_W];

    assign p_xy = (2*W_W)'(wx) * (2*W_W)'(wy);
    assign p_xz = (2*W_W)'(wx) * (2*W_W)'(wz);
    assign p_yz = (2*W_W)'(wy) * (2*W_W)'(wz);
    assign p_w  = (2*W_W)'(pxy_reg) * (2*W_W)'(wz);
    assign p_tx = 49'(pyz_reg) * 49'(rd_den);
    assign p_ty = 49'(pxz_reg) * 49'(rd_den);
    assign p_tz = 49'(pxy_reg) * 49'(rd_den);
    assign w_s  = 34'($signed({1'b0, w_reg}));
    assign p_qw = 50'(q_reg) * 50'(w_s);
    assign qw_ext = ACC_W'(qw_reg);

    assign den_sum = {1'b0, rd_den} + (DEN_W+1)'(w_reg);
    assign den_new = den_sum[DEN_W] ? {DEN_W{1'b1}} : den_sum[DEN_W-1:0];

    // divider operand: first axis starts from the gradient step, later ones from the
    // average step; the sign of the axis being divided decides the quotient sign
    assign div_axis = (state_reg == B_QACC) ? axis_reg + 2'd1 : 2'd0;
    always_comb begin
        case (div_axis)
            2'd0:    vs_div = rd_vx;
            2'd1:    vs_div = rd_vy;
            default: vs_div = rd_vz;
        endcase
        case (axis_reg)
            2'd0:    vs_cur = rd_vx;
            2'd1:    vs_cur = rd_vy;
            default: vs_cur = rd_vz;
        endcase
    end
    assign div_mag = vs_div[SUM_W-1] ? SUM_W'(-vs_div) : SUM_W'(vs_div);

    vgsg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (rd_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: begin
                if (clr_reg == LAST_A) begin
                    state_next = init_reg ? B_IDLE : B_DONE;
                end
            end
            B_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_CLEAR:  state_next = B_CLEAR;
                        CMD_SPLAT:  state_next = B_RD;
                        CMD_GATHER: state_next = B_RD;
                        default:    state_next = B_DONE;
                    endcase
                end
            end
            B_RD:  state_next = B_WGT;
            B_WGT: state_next = (cmd_reg.kind == CMD_SPLAT) ? B_SPL : B_GT;
            B_SPL: state_next = B_WR;
            B_WR:  state_next = last_corner ? B_DONE : B_RD;
            B_GT: begin
                if (rd_den == '0) begin
                    state_next = last_corner ? B_DONE : B_RD;
                end else begin
                    state_next = B_GACC;
                end
            end
            B_GACC: state_next = B_DIV;
            B_DIV:  state_next = div_done ? B_QMUL : B_DIV;
            B_QMUL: state_next = B_QACC;
            B_QACC: begin
                if (axis_reg != 2'd2) begin
                    state_next = B_DIV;
                end else begin
                    state_next = last_corner ? B_DONE : B_RD;
                end
            end
            B_DONE: state_next = out_free ? B_IDLE : B_DONE;
            default: state_next = B_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        cmd_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = cell_addr;
        mem_wdata   = '0;
        div_start   = 1'b0;
        cmd_next    = cmd_reg;
        corner_next = corner_reg;
        axis_next   = axis_reg;
        clr_next    = clr_reg;
        init_next   = init_reg;
        pxy_next    = pxy_reg;
        pxz_next    = pxz_reg;
        pyz_next    = pyz_reg;
        w_next      = w_reg;
        vwx_next    = vwx_reg;
        vwy_next    = vwy_reg;
        vwz_next    = vwz_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        tz_next     = tz_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        gz_next     = gz_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        az_next     = az_reg;
        q_next      = q_reg;
        qw_next     = qw_reg;
        oax_next    = oax_reg;
        oay_next    = oay_reg;
        oaz_next    = oaz_reg;
        ogx_next    = ogx_reg;
        ogy_next    = ogy_reg;
        ogz_next    = ogz_reg;
        ost_next    = ost_reg;
        m_valid_next = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;

        case (state_reg)
            B_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_A) begin
                    init_next = 1'b0;
                end
            end
            B_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd;
                    corner_next = 3'd0;
                    clr_next    = '0;
                    gx_next     = '0;
                    gy_next     = '0;
                    gz_next     = '0;
                    ax_next     = '0;
                    ay_next     = '0;
                    az_next     = '0;
                end
            end
            B_RD: begin
                mem_re   = 1'b1;
                pxy_next = p_xy[W_W+15:16];
                pxz_next = p_xz[W_W+15:16];
                pyz_next = p_yz[W_W+15:16];
            end
            B_WGT: begin
                w_next = p_w[W_W+15:16];
            end
            B_SPL: begin
                vwx_next = 34'(cmd_reg.vel_x) * w_s;
                vwy_next = 34'(cmd_reg.vel_y) * w_s;
                vwz_next = 34'(cmd_reg.vel_z) * w_s;
            end
            B_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {sat_sum((SUM_W+1)'(rd_vz) + (SUM_W+1)'(vwz_reg)),
                             sat_sum((SUM_W+1)'(rd_vy) + (SUM_W+1)'(vwy_reg)),
                             sat_sum((SUM_W+1)'(rd_vx) + (SUM_W+1)'(vwx_reg)),
                             den_new};
                corner_next = corner_reg + 3'd1;
            end
            B_GT: begin
                tx_next = p_tx[48:16];
                ty_next = p_ty[48:16];
                tz_next = p_tz[48:16];
                if (rd_den == '0) begin
                    corner_next = corner_reg + 3'd1;
                end
            end
            B_GACC: begin
                gx_next   = dx ? gx_reg - ACC_W'(tx_reg) : gx_reg + ACC_W'(tx_reg);
                gy_next   = dy ? gy_reg - ACC_W'(ty_reg) : gy_reg + ACC_W'(ty_reg);
                gz_next   = dz ? gz_reg - ACC_W'(tz_reg) : gz_reg + ACC_W'(tz_reg);
                axis_next = 2'd0;
                div_start = 1'b1;
            end
            B_DIV: begin
                if (div_done) begin
                    if (!vs_cur[SUM_W-1]) begin
                        q_next = (div_quo > SUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                   : div_quo[31:0];
                    end else begin
                        q_next = (div_quo > SUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                                   : -div_quo[31:0];
                    end
                end
            end
            B_QMUL: begin
                qw_next = p_qw[49:16];   // upper bits of two's complement give floor
            end
            B_QACC: begin
                case (axis_reg)
                    2'd0:    ax_next = ax_reg + qw_ext;
                    2'd1:    ay_next = ay_reg + qw_ext;
                    default: az_next = az_reg + qw_ext;
                endcase
                if (axis_reg != 2'd2) begin
                    axis_next = axis_reg + 2'd1;
                    div_start = 1'b1;
                end else begin
                    corner_next = corner_reg + 3'd1;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ost_next     = cmd_reg.status;
                    if (cmd_reg.kind == CMD_GATHER) begin
                        oax_next = sat_avg(ax_reg);
                        oay_next = sat_avg(ay_reg);
                        oaz_next = sat_avg(az_reg);
                        ogx_next = sat_grad(gx_reg);
                        ogy_next = sat_grad(gy_reg);
                        ogz_next = sat_grad(gz_reg);
                    end else begin
                        oax_next = '0;
                        oay_next = '0;
                        oaz_next = '0;
                        ogx_next = '0;
                        ogy_next = '0;
                        ogz_next = '0;
                    end
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            corner_reg  <= 3'd0;
            axis_reg    <= 2'd0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
            corner_reg  <= corner_next;
            axis_reg    <= axis_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        pxy_reg <= pxy_next;
        pxz_reg <= pxz_next;
        pyz_reg <= pyz_next;
        w_reg   <= w_next;
        vwx_reg <= vwx_next;
        vwy_reg <= vwy_next;
        vwz_reg <= vwz_next;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        tz_reg  <= tz_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        gz_reg  <= gz_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        q_reg   <= q_next;
        qw_reg  <= qw_next;
        oax_reg <= oax_next;
        oay_reg <= oay_next;
        oaz_reg <= oaz_next;
        ogx_reg <= ogx_next;
        ogy_reg <= ogy_next;
        ogz_reg <= ogz_next;
        ost_reg <= ost_next;
    end

    assign init_busy = init_reg;
    assign m_tvalid  = m_valid_reg;
    assign avg_vel_x = oax_reg;
    assign avg_vel_y = oay_reg;
    assign avg_vel_z = oaz_reg;
    assign grad_x    = ogx_reg;
    assign grad_y    = ogy_reg;
    assign grad_z    = ogz_reg;
    assign status    = ost_reg;

endmodule

>>> src/voxel_grid_splat_gather.sv
// Top level of the voxel grid splat and gather block.
// Input stream s_*: tuser carries the action (clear, splat, gather, none); tdata carries
// the position and, for splat, the particle velocity. Every item gives one result item
// on m_*: tdata holds the averaged velocity and the density gradient (zero unless a
// gather ran), tuser holds the status flag (set when a splat or gather position lies off the grid).
// A two-entry queue sits between the decoding front and the grid sequencer, so items
// are taken while the sequencer is busy and a finished result waits in its own
// register while the next item is already being worked on.
// The sequencer walks the eight corners one after another through one memory port:
//   splat: each corner is read, weighted, multiplied into the velocity and written back.
//   gather: each corner of nonzero density runs the 48-step divider once per axis;
//   an empty corner is skipped after its read.
//   clear: every cell is zeroed, one cell written per cycle.
//   off-grid and unused actions go straight to the result.
// After reset the grid is swept to zero; s_tready stays low until the sweep ends.
// A stalled receiver holds m_tdata; s_tready drops whenever the two-entry queue
// is full.
module voxel_grid_splat_gather #(
    parameter int GRID_SIZE = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
    input  logic [1:0]    s_tuser,   // action
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata,   // avg_vel_x, avg_vel_y, avg_vel_z, grad_x, grad_y, grad_z
    output logic [0:0]    m_tuser    // status
);
    import vgsg_pkg::*;

    cmd_t       push_cmd, head_cmd;
    logic       push, q_full, q_not_empty, pop, init_busy;
    logic [1:0] q_count;
    logic signed [AVG_W-1:0]  avg_x, avg_y, avg_z;
    logic signed [GRAD_W-1:0] g_x, g_y, g_z;
    logic                     st;

    vgsg_front #(
        .GRID_SIZE (GRID_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (action_t'(s_tuser)),
        .pos_x     (s_tdata[13:0]),
        .pos_y     (s_tdata[27:14]),
        .pos_z     (s_tdata[41:28]),
        .vel_x     (s_tdata[57:42]),
        .vel_y     (s_tdata[73:58]),
        .vel_z     (s_tdata[89:74]),
        .q_full    (q_full),
        .init_busy (init_busy),
        .push      (push),
        .cmd       (push_cmd)
    );

    vgsg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head_cmd),
        .count     (q_count)
    );

    vgsg_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .avg_vel_x (avg_x),
        .avg_vel_y (avg_y),
        .avg_vel_z (avg_z),
        .grad_x    (g_x),
        .grad_y    (g_y),
        .grad_z    (g_z),
        .status    (st)
    );

    assign m_tdata = {g_z, g_y, g_x, avg_z, avg_y, avg_x};
    assign m_tuser = st;

    a_init_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !s_tready)
        else $error("item taken during reset sweep");

    a_skip_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("off-grid result carries data");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= 2'd2 && !(q_count == 2'd2 && push && !pop))
        else $error("command queue overflow");

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_not_empty)
        else $error("pop from empty queue");

endmodule
